>>> rtl/core/i2cmw_pkg.sv
// shared types and constants for the i2c master write sequencer
// no dependencies; every other file of the block refers to this package
package i2cmw_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = 2;
    localparam int FIFO_CW          = 3;
    localparam int MEM_ADDR_W       = 8;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
    localparam logic [5:0]  POS_MAX       = 6'd63;

    // controller status codes
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_ADDR_NAK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_DATA_NAK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST = 8'h38;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_LOAD   = 2'd1,
        FN_STATUS = 2'd2,
        FN_TICK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_OK      = 2'd1,
        RES_FAILED  = 2'd2,
        RES_TIMEOUT = 2'd3
    } t_outcome;

    typedef struct packed {
        t_func      func;
        logic [6:0] slave_address;
        logic [5:0] byte_count;
        logic [4:0] byte_index;
        logic [7:0] data_byte;
        logic [7:0] status_code;
    } t_item;

    typedef struct packed {
        logic       load_data_valid;
        logic [7:0] data_out;
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic       clear_interrupt;
        t_outcome   outcome;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic                  re;
        logic [MEM_ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage

>>> rtl/core/i2cmw_if.sv
// valid/ready channel interfaces: command input, result output, config write
// uses i2cmw_pkg for the field types
interface i2cmw_in_if;
    logic                valid;
    logic                ready;
    i2cmw_pkg::t_func    func;
    logic [6:0]          slave_address;
    logic [5:0]          byte_count;
    logic [4:0]          byte_index;
    logic [7:0]          data_byte;
    logic [7:0]          status_code;

    modport source (
        output valid, func, slave_address, byte_count, byte_index, data_byte, status_code,
        input  ready
    );
    modport sink (
        input  valid, func, slave_address, byte_count, byte_index, data_byte, status_code,
        output ready
    );
endinterface

interface i2cmw_out_if;
    logic                valid;
    logic                ready;
    logic                load_data_valid;
    logic [7:0]          data_out;
    logic                set_start;
    logic                clear_start;
    logic                set_stop;
    logic                clear_interrupt;
    i2cmw_pkg::t_outcome outcome;
    logic                busy_res;

    modport source (
        output valid, load_data_valid, data_out, set_start, clear_start, set_stop,
               clear_interrupt, outcome, busy_res,
        input  ready
    );
    modport sink (
        input  valid, load_data_valid, data_out, set_start, clear_start, set_stop,
               clear_interrupt, outcome, busy_res,
        output ready
    );
endinterface

interface i2cmw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/i2cmw_buf.sv
// transmit buffer: one write port, one registered read port
// uses i2cmw_pkg for the request struct
module i2cmw_buf #(
    parameter int BUFFER_DEPTH = i2cmw_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  i2cmw_pkg::t_mem_req i_req,
    output logic [7:0]          o_rd_data
);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/i2cmw_seq.sv
// transaction sequencer: decides each beat, keeps the transaction registers,
// drives the buffer ports and holds the beat while its buffer read completes
// uses i2cmw_pkg
module i2cmw_seq #(
    parameter int BUFFER_DEPTH = i2cmw_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  i2cmw_pkg::t_item    i_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    output i2cmw_pkg::t_mem_req o_mem,
    input  logic [7:0]          i_rd_data,
    output logic                o_res_valid,
    output i2cmw_pkg::t_result  o_res
);
    localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

    logic                r_busy, n_busy;
    logic [5:0]          r_pos, n_pos;
    logic [6:0]          r_addr, n_addr;
    logic [5:0]          r_len, n_len;
    logic [15:0]         r_elapsed, n_elapsed;
    i2cmw_pkg::t_outcome r_outcome, n_outcome;
    logic [15:0]         r_limit;

    // beat waiting for its buffer read
    logic                r_s1_valid;
    i2cmw_pkg::t_result  r_s1, n_s1;
    logic                r_s1_mem, n_s1_mem;

    logic [15:0] el_tick;
    logic [5:0]  pos_inc;
    logic [5:0]  rd_pos;
    logic        rd_en;

    always_comb begin
        n_busy    = r_busy;
        n_pos     = r_pos;
        n_addr    = r_addr;
        n_len     = r_len;
        n_elapsed = r_elapsed;
        n_outcome = r_outcome;
        n_s1      = '0;
        n_s1_mem  = 1'b0;
        rd_pos    = r_pos;
        rd_en     = 1'b0;
        o_mem     = '0;

        el_tick = r_elapsed;
        if (i_item.func == i2cmw_pkg::FN_TICK && r_busy && r_elapsed != i2cmw_pkg::ELAPSED_MAX) begin
            el_tick = r_elapsed + 16'd1;
        end
        pos_inc = (r_pos < i2cmw_pkg::POS_MAX) ? r_pos + 6'd1 : r_pos;

        unique case (i_item.func)
            i2cmw_pkg::FN_START: begin
                n_addr            = i_item.slave_address;
                n_len             = i_item.byte_count;
                n_outcome         = i2cmw_pkg::RES_NONE;
                n_elapsed         = '0;
                n_busy            = 1'b1;
                n_s1.set_start    = 1'b1;
                n_s1.clear_interrupt = 1'b1;
            end
            i2cmw_pkg::FN_LOAD: begin
                o_mem.we      = i_accept && ({4'b0000, i_item.byte_index} < DEPTH9);
                o_mem.wr_addr = {3'b000, i_item.byte_index};
                o_mem.wr_data = i_item.data_byte;
            end
            default: begin
                n_elapsed = el_tick;
                if (r_busy && el_tick >= r_limit) begin
                    n_outcome            = i2cmw_pkg::RES_TIMEOUT;
                    n_busy               = 1'b0;
                    n_s1.set_stop        = 1'b1;
                    n_s1.clear_interrupt = 1'b1;
                end else if (i_item.func == i2cmw_pkg::FN_STATUS) begin
                    unique case (i_item.status_code) inside
                        i2cmw_pkg::ST_START, i2cmw_pkg::ST_RESTART: begin
                            n_s1.load_data_valid = 1'b1;
                            n_s1.data_out        = {r_addr, 1'b0};
                            n_pos                = '0;
                            n_s1.clear_interrupt = 1'b1;
                        end
                        i2cmw_pkg::ST_ADDR_ACK: begin
                            n_s1.load_data_valid = 1'b1;
                            n_s1_mem             = 1'b1;
                            rd_pos               = r_pos;
                            rd_en                = 1'b1;
                            n_s1.clear_start     = 1'b1;
                            n_s1.clear_interrupt = 1'b1;
                        end
                        i2cmw_pkg::ST_DATA_ACK: begin
                            n_pos = pos_inc;
                            if (pos_inc >= r_len) begin
                                n_outcome     = i2cmw_pkg::RES_OK;
                                n_busy        = 1'b0;
                                n_s1.set_stop = 1'b1;
                            end else begin
                                n_s1.load_data_valid = 1'b1;
                                n_s1_mem             = 1'b1;
                                rd_pos               = pos_inc;
                                rd_en                = 1'b1;
                            end
                            n_s1.clear_interrupt = 1'b1;
                        end
                        i2cmw_pkg::ST_ADDR_NAK, i2cmw_pkg::ST_DATA_NAK: begin
                            n_outcome            = i2cmw_pkg::RES_FAILED;
                            n_busy               = 1'b0;
                            n_s1.set_stop        = 1'b1;
                            n_s1.clear_interrupt = 1'b1;
                        end
                        i2cmw_pkg::ST_ARB_LOST: begin
                            n_outcome            = i2cmw_pkg::RES_FAILED;
                            n_busy               = 1'b0;
                            n_s1.set_start       = 1'b1;
                            n_s1.clear_interrupt = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase

        // positions past the buffer read as zero, so no read is issued
        o_mem.re      = i_accept && rd_en && ({3'b000, rd_pos} < DEPTH9);
        o_mem.rd_addr = {2'b00, rd_pos};

        n_s1.outcome  = n_outcome;
        n_s1.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pos      <= '0;
            r_addr     <= '0;
            r_len      <= '0;
            r_elapsed  <= '0;
            r_outcome  <= i2cmw_pkg::RES_NONE;
            r_limit    <= i2cmw_pkg::TIMEOUT_RESET;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_busy    <= n_busy;
                r_pos     <= n_pos;
                r_addr    <= n_addr;
                r_len     <= n_len;
                r_elapsed <= n_elapsed;
                r_outcome <= n_outcome;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1     <= n_s1;
            // an out-of-range read keeps the zero already in data_out
            r_s1_mem <= n_s1_mem && o_mem.re;
        end
    end

    always_comb begin
        o_res = r_s1;
        if (r_s1_mem) begin
            o_res.data_out = i_rd_data;
        end
    end

    assign o_res_valid = r_s1_valid;

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.func == i2cmw_pkg::FN_START |=> r_busy && r_elapsed == 16'd0)
        else $error("start beat did not open a transaction");

    a_timeout_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_busy && r_elapsed >= r_limit
        && (i_item.func == i2cmw_pkg::FN_STATUS || i_item.func == i2cmw_pkg::FN_TICK)
        |=> !r_busy && r_outcome == i2cmw_pkg::RES_TIMEOUT)
        else $error("expired transaction not closed with timeout");

    a_read_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.re |-> i_accept && !o_mem.we)
        else $error("buffer access without an accepted beat");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1.set_stop || r_s1.outcome != i2cmw_pkg::RES_NONE) |-> !r_s1.busy_res)
        else $error("finished result still reports busy");

endmodule

>>> rtl/core/i2cmw_out_fifo.sv
// result queue between the sequencer and the output channel
// uses i2cmw_pkg for the result struct and queue depth
module i2cmw_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  i2cmw_pkg::t_result             i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output i2cmw_pkg::t_result             o_data,
    output logic [i2cmw_pkg::FIFO_CW-1:0]  o_count
);
    i2cmw_pkg::t_result                 r_mem [i2cmw_pkg::FIFO_DEPTH];
    logic [i2cmw_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [i2cmw_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [i2cmw_pkg::FIFO_CW-1:0]      r_count;
    logic                               pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < i2cmw_pkg::FIFO_CW'(i2cmw_pkg::FIFO_DEPTH) || pop)
        else $error("result queue overflow");

endmodule

>>> rtl/core/i2c_master_write_sequencer_core.sv
// Takes one command beat per clock and returns exactly one result beat for each, in
// order. The sequencer decides each accepted beat and reads the transmit buffer, then
// the registered beat takes the buffer byte into a four-entry result queue. Input
// ready stays high as long as the queue can absorb every beat in flight, so with the
// output sink ready the block runs at one beat per cycle; a stalled sink fills the
// queue and then holds input ready low. The timeout register port is always ready,
// and a write is registered into the timeout limit.
// depends on i2cmw_pkg, i2cmw_if, i2cmw_buf, i2cmw_seq, i2cmw_out_fifo
module i2c_master_write_sequencer_core #(
    parameter int BUFFER_DEPTH = i2cmw_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cmw_in_if.sink    i_in,
    i2cmw_out_if.source o_out,
    i2cmw_cfg_if.sink   i_cfg
);
    i2cmw_pkg::t_item                  item;
    i2cmw_pkg::t_mem_req               mem_req;
    i2cmw_pkg::t_result                s1_res;
    i2cmw_pkg::t_result                q_res;
    logic [7:0]                        rd_data;
    logic                              s1_valid;
    logic                              q_valid;
    logic [i2cmw_pkg::FIFO_CW-1:0]     q_count;
    logic [i2cmw_pkg::FIFO_CW-1:0]     in_flight;
    logic                              accept;

    assign item.func          = i_in.func;
    assign item.slave_address = i_in.slave_address;
    assign item.byte_count    = i_in.byte_count;
    assign item.byte_index    = i_in.byte_index;
    assign item.data_byte     = i_in.data_byte;
    assign item.status_code   = i_in.status_code;

    // every beat in flight needs a queue slot waiting for it
    assign in_flight  = q_count + {{(i2cmw_pkg::FIFO_CW-1){1'b0}}, s1_valid};
    assign i_in.ready = in_flight < i2cmw_pkg::FIFO_CW'(i2cmw_pkg::FIFO_DEPTH);
    assign accept     = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    i2cmw_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (s1_valid),
        .o_res       (s1_res)
    );

    i2cmw_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    i2cmw_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_valid),
        .i_data  (s1_res),
        .i_pop   (o_out.ready),
        .o_valid (q_valid),
        .o_data  (q_res),
        .o_count (q_count)
    );

    assign o_out.valid           = q_valid;
    assign o_out.load_data_valid = q_res.load_data_valid;
    assign o_out.data_out        = q_res.data_out;
    assign o_out.set_start       = q_res.set_start;
    assign o_out.clear_start     = q_res.clear_start;
    assign o_out.set_stop        = q_res.set_stop;
    assign o_out.clear_interrupt = q_res.clear_interrupt;
    assign o_out.outcome         = q_res.outcome;
    assign o_out.busy_res        = q_res.busy_res;

endmodule
